FILE: hw/rtl/tgql_pkg.sv
package tgql_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_VIEW_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_H = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ASCENT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STEP = 3'd6;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_CHAR = 2'd2;

  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] NEWLINE = 8'd10;

  localparam int PEN_W = 20;
  localparam logic signed [PEN_W-1:0] PEN_MAX = 20'sh7FFFF;
  localparam logic signed [PEN_W-1:0] PEN_MIN = 20'sh80000;

  // divider numerator magnitude width and quotient width
  localparam int NUM_W = 38;
  localparam int DEN_W = 13;
  localparam int QUO_W = NUM_W + 2;

  typedef struct packed {
    logic [7:0] gh;
    logic [7:0] gw;
    logic [11:0] ay;
    logic [11:0] ax;
  } place_t;

  typedef struct packed {
    logic [7:0] adv;
    logic signed [8:0] by;
    logic signed [8:0] bx;
  } metrics_t;

  typedef struct packed {
    logic start;
    logic neg;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [QUO_W:0] quo;
  } div_rsp_t;

endpackage

FILE: hw/rtl/tgql_if.sv
interface tgql_in_if;
  logic valid;
  logic ready;
  logic [1:0] command;
  logic [7:0] code;
  logic [11:0] atlas_x;
  logic [11:0] atlas_y;
  logic [7:0] glyph_w;
  logic [7:0] glyph_h;
  logic signed [8:0] offset_x;
  logic signed [8:0] offset_y;
  logic [7:0] advance;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic [31:0] tint;
  modport source(output valid, command, code, atlas_x, atlas_y, glyph_w, glyph_h,
    offset_x, offset_y, advance, start_x, start_y, tint, input ready);
  modport sink(input valid, command, code, atlas_x, atlas_y, glyph_w, glyph_h,
    offset_x, offset_y, advance, start_x, start_y, tint, output ready);
endinterface

interface tgql_out_if;
  logic valid;
  logic ready;
  logic signed [17:0] ndc_x;
  logic signed [17:0] ndc_y;
  logic [15:0] tex_u;
  logic [15:0] tex_v;
  logic [31:0] color;
  logic [1:0] corner;
  logic last;
  modport source(output valid, ndc_x, ndc_y, tex_u, tex_v, color, corner, last,
    input ready);
  modport sink(input valid, ndc_x, ndc_y, tex_u, tex_v, color, corner, last,
    output ready);
endinterface

FILE: hw/rtl/tgql_ram.sv
module tgql_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/tgql_div.sv
module tgql_div (
  input  logic               clk,
  input  logic               rst,
  input  tgql_pkg::div_req_t req,
  output tgql_pkg::div_rsp_t rsp
);
  import tgql_pkg::*;

  // restoring divide of (2|num| + den) by 2den, one quotient bit a cycle
  localparam int RW = NUM_W + 2;
  localparam int CNT_W = $clog2(RW + 1);

  logic [RW-1:0] dividend;
  logic [RW-1:0] rem;
  logic [RW:0] dsor;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic neg;
  logic done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(RW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  logic [RW:0] shifted;
  assign shifted = {rem, dividend[RW-1]};

  always_ff @(posedge clk) begin
    if (req.start) begin
      dividend <= {req.num, 1'b0} + RW'(req.den);
      rem <= '0;
      dsor <= {(RW - DEN_W)'(0), req.den, 1'b0};
      neg <= req.neg;
    end else if (busy) begin
      dividend <= {dividend[RW-2:0], 1'b0};
      if (shifted >= dsor) begin
        rem <= RW'(shifted - dsor);
        dividend[0] <= 1'b1;
      end else begin
        rem <= shifted[RW-1:0];
        dividend[0] <= 1'b0;
      end
    end
  end

  logic [QUO_W:0] mag;
  assign mag = {1'b0, dividend};
  assign rsp.done = done;
  assign rsp.quo = neg ? -$signed(mag) : $signed(mag);
endmodule

FILE: hw/rtl/text_glyph_quad_layout.sv
// load, begin, newline and skipped codes go from S_READ back to idle, a zero-size
// glyph via S_DECIDE; a drawn glyph computes eight quotients on one shared
// bit-serial divider, then presents four vertices. One item at a time;
// in.ready is low while an item is in work
// rst (synchronous) resets config registers (view 1024, atlas 1, others 0),
// clears pen, baseline and tint; glyph table is undefined until loaded
module text_glyph_quad_layout #(
  parameter int GLYPH_SLOTS = 224
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tgql_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tgql_pkg::CFG_DATA_W-1:0] cfg_data,
  tgql_in_if.sink                        in,
  tgql_out_if.source                     out
);
  import tgql_pkg::*;

  localparam int SLOT_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [12:0] view_w, view_h, atlas_w, atlas_h;
  logic [7:0] glyph_count;
  logic [9:0] ascent, line_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_w <= 13'd1024;
      view_h <= 13'd1024;
      atlas_w <= 13'd1;
      atlas_h <= 13'd1;
      glyph_count <= '0;
      ascent <= '0;
      line_step <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VIEW_W: view_w <= cfg_data;
        REG_VIEW_H: view_h <= cfg_data;
        REG_ATLAS_W: atlas_w <= cfg_data;
        REG_ATLAS_H: atlas_h <= cfg_data;
        REG_GLYPH_COUNT: glyph_count <= cfg_data[7:0];
        REG_ASCENT: ascent <= cfg_data[9:0];
        REG_LINE_STEP: line_step <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic [2:0] state;
  logic [1:0] cmd;
  logic [7:0] code;
  logic [31:0] tint_in;
  logic signed [15:0] sx, sy;
  logic signed [PEN_W-1:0] pen_x, baseline_y;
  logic signed [15:0] line_start_x;
  logic [31:0] held_tint;
  logic [2:0] op;
  logic signed [17:0] res [8];
  logic [1:0] k;

  logic load_ok, ram_we;
  assign load_ok = {1'b0, in.code} < 9'(GLYPH_SLOTS);
  assign ram_we = in.valid && in.ready && in.command == CMD_LOAD && load_ok;

  logic [8:0] count;
  assign count = ({1'b0, glyph_count} > 9'(GLYPH_SLOTS)) ? 9'(GLYPH_SLOTS)
                                                          : {1'b0, glyph_count};
  logic [8:0] slot9;
  assign slot9 = {1'b0, code} - 9'd32;

  place_t pl;
  metrics_t mt;
  place_t pl_w;
  metrics_t mt_w;
  assign pl_w = '{gh: in.glyph_h, gw: in.glyph_w, ay: in.atlas_y, ax: in.atlas_x};
  assign mt_w = '{adv: in.advance, by: in.offset_y, bx: in.offset_x};

  tgql_ram #(.WIDTH(40), .DEPTH(GLYPH_SLOTS)) u_place (
    .clk(clk), .we(ram_we), .waddr(in.code[SLOT_W-1:0]), .wdata(pl_w),
    .raddr(slot9[SLOT_W-1:0]), .rdata(pl));
  tgql_ram #(.WIDTH(26), .DEPTH(GLYPH_SLOTS)) u_metrics (
    .clk(clk), .we(ram_we), .waddr(in.code[SLOT_W-1:0]), .wdata(mt_w),
    .raddr(slot9[SLOT_W-1:0]), .rdata(mt));

  // glyph geometry
  logic signed [21:0] x0, y0, x1, y1;
  assign x0 = 22'(pen_x) + 22'(mt.bx);
  assign y0 = 22'(baseline_y) - 22'(mt.by);
  assign x1 = x0 + 22'($signed({1'b0, pl.gw}));
  assign y1 = y0 + 22'($signed({1'b0, pl.gh}));
  logic [13:0] u0n, u1n, v0n, v1n;
  always_comb begin
    u0n = {1'b0, pl.ax, 1'b1};
    u1n = {1'b0, pl.ax, 1'b0} + {5'd0, pl.gw, 1'b0} - 14'd1;
    v0n = {1'b0, pl.ay, 1'b1};
    v1n = {1'b0, pl.ay, 1'b0} + {5'd0, pl.gh, 1'b0} - 14'd1;
    if (pl.gw <= 8'd1) begin
      u0n = {1'b0, pl.ax, 1'b0} + 14'(pl.gw);
      u1n = u0n;
    end
    if (pl.gh <= 8'd1) begin
      v0n = {1'b0, pl.ay, 1'b0} + 14'(pl.gh);
      v1n = v0n;
    end
  end

  logic [12:0] vw1, vh1, aw1, ah1;
  assign vw1 = (view_w == '0) ? 13'd1 : view_w;
  assign vh1 = (view_h == '0) ? 13'd1 : view_h;
  assign aw1 = (atlas_w == '0) ? 13'd1 : atlas_w;
  assign ah1 = (atlas_h == '0) ? 13'd1 : atlas_h;

  // operand for op: 0 x0, 1 x1, 2 y0, 3 y1, 4 u0, 5 u1, 6 v0, 7 v1
  logic signed [NUM_W:0] num_s;
  logic [12:0] den_sel;
  always_comb begin
    unique case (op)
      3'd0: begin num_s = ((NUM_W+1)'(x0) <<< 15) - (NUM_W+1)'({vw1, 14'd0});
        den_sel = vw1; end
      3'd1: begin num_s = ((NUM_W+1)'(x1) <<< 15) - (NUM_W+1)'({vw1, 14'd0});
        den_sel = vw1; end
      3'd2: begin num_s = (NUM_W+1)'({vh1, 14'd0}) - ((NUM_W+1)'(y0) <<< 15);
        den_sel = vh1; end
      3'd3: begin num_s = (NUM_W+1)'({vh1, 14'd0}) - ((NUM_W+1)'(y1) <<< 15);
        den_sel = vh1; end
      3'd4: begin num_s = (NUM_W+1)'({u0n, 15'd0}); den_sel = aw1; end
      3'd5: begin num_s = (NUM_W+1)'({u1n, 15'd0}); den_sel = aw1; end
      3'd6: begin num_s = (NUM_W+1)'({v0n, 15'd0}); den_sel = ah1; end
      default: begin num_s = (NUM_W+1)'({v1n, 15'd0}); den_sel = ah1; end
    endcase
  end

  div_req_t dreq;
  div_rsp_t drsp;
  assign dreq.neg = num_s[NUM_W];
  assign dreq.num = num_s[NUM_W] ? NUM_W'(-num_s) : num_s[NUM_W-1:0];
  assign dreq.den = den_sel;
  assign dreq.start = (state == S_DIV);

  tgql_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic signed [17:0] sat;
  always_comb begin
    if (op[2]) begin
      if (drsp.quo > 27'sd65535) sat = 18'sd65535;
      else if (drsp.quo < 0) sat = '0;
      else sat = 18'(drsp.quo);
    end else begin
      if (drsp.quo > 27'sd131071) sat = 18'sh1FFFF;
      else if (drsp.quo < -27'sd131072) sat = 18'sh20000;
      else sat = 18'(drsp.quo);
    end
  end

  function automatic logic signed [PEN_W-1:0] pen_sat(input logic signed [PEN_W+1:0] v);
    if (v > (PEN_W+2)'(PEN_MAX)) return PEN_MAX;
    if (v < (PEN_W+2)'(PEN_MIN)) return PEN_MIN;
    return PEN_W'(v);
  endfunction

  logic signed [PEN_W-1:0] pen_adv;
  assign pen_adv = pen_sat((PEN_W+2)'(pen_x) + (PEN_W+2)'($signed({1'b0, mt.adv})));

  assign in.ready = (state == S_IDLE);
  assign out.valid = (state == S_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pen_x <= '0;
      baseline_y <= '0;
      line_start_x <= '0;
      held_tint <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in.valid) begin
          cmd <= in.command;
          code <= in.code;
          sx <= in.start_x;
          sy <= in.start_y;
          tint_in <= in.tint;
          state <= S_READ;
        end
        S_READ: begin
          state <= S_IDLE;
          if (cmd == CMD_BEGIN) begin
            line_start_x <= sx;
            pen_x <= PEN_W'(sx);
            baseline_y <= PEN_W'(sy) + PEN_W'(ascent);
            held_tint <= tint_in;
          end else if (cmd == CMD_CHAR && count != '0) begin
            if (code == NEWLINE) begin
              pen_x <= PEN_W'(line_start_x);
              baseline_y <= pen_sat((PEN_W+2)'(baseline_y) + (PEN_W+2)'(line_step));
            end else if (code >= FIRST_CODE && {1'b0, code} < 9'd32 + count) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (pl.gw == '0 || pl.gh == '0) begin
            pen_x <= pen_adv;
            state <= S_IDLE;
          end else begin
            op <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: if (drsp.done) begin
          res[op] <= sat;
          op <= op + 1'b1;
          if (op == 3'd7) begin
            k <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_DIV;
          end
        end
        S_EMIT: if (out.ready) begin
          k <= k + 1'b1;
          if (k == 2'd3) begin
            pen_x <= pen_adv;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out.ndc_x = (k == 2'd1 || k == 2'd2) ? res[1] : res[0];
  assign out.ndc_y = (k[1]) ? res[3] : res[2];
  assign out.tex_u = 16'((k == 2'd1 || k == 2'd2) ? res[5] : res[4]);
  assign out.tex_v = 16'((k[1]) ? res[6] : res[7]);
  assign out.color = held_tint;
  assign out.corner = k;
  assign out.last = (k == 2'd3);

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> !in.ready) else $error("ready while emitting");
  a_last: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.ready && out.last) |=> state == S_IDLE)
    else $error("no return to idle after last vertex");
  a_done: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> state == S_WAIT) else $error("divider done out of step");
`endif
endmodule
